// ----- hdl/ufc_pkg.sv -----
// ----------------------------------------------------------------------------
// ufc_pkg
// shared types and constants of the uart idle-gap frame checker
// ----------------------------------------------------------------------------
`default_nettype none

package ufc_pkg;

    localparam int UFC_BUF_DEPTH = 256;

    localparam logic [19:0] UFC_TIMEOUT_RST = 20'd20000;
    localparam logic [7:0]  UFC_START_RST   = 8'h3a;
    localparam logic [7:0]  UFC_ADDRESS_RST = 8'h16;

    localparam logic [7:0]  UFC_TRAIL_CR    = 8'h0d;
    localparam logic [7:0]  UFC_TRAIL_LF    = 8'h0a;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_IDLE_TIMEOUT = 2'd0,
        REG_START_BYTE   = 2'd1,
        REG_ADDRESS_BYTE = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_CKSUM_ERR = 2'd0,
        ST_FRAME_ERR = 2'd1,
        ST_FRAME_OK  = 2'd2
    } status_t;

    // checker sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM,
        S_CKLO,
        S_CKHI,
        S_HB0,
        S_HB1,
        S_HB3,
        S_HB4,
        S_TCR,
        S_TLF,
        S_FIN,
        S_DONE
    } chk_state_t;

    typedef struct packed {
        logic       start;
        logic [7:0] nbytes;
    } chk_req_t;

    typedef struct packed {
        logic       valid;
        status_t    status;
        logic [7:0] command;
        logic [7:0] length_field;
        logic [7:0] frame_bytes;
    } chk_res_t;

endpackage

`default_nettype wire

// ----- hdl/ufc_frame_mem.sv -----
// ----------------------------------------------------------------------------
// ufc_frame_mem
// frame byte store, one write and one registered read port, per-entry valid
// bits make unwritten entries read as zero after reset
// ----------------------------------------------------------------------------
`default_nettype none

module ufc_frame_mem
    import ufc_pkg::*;
#(
    parameter int BUF_DEPTH = UFC_BUF_DEPTH,
    parameter int AW        = $clog2(BUF_DEPTH)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);

    localparam logic [AW:0] DEPTH_W = (AW+1)'(BUF_DEPTH);

    logic [7:0]           mem [BUF_DEPTH];
    logic [BUF_DEPTH-1:0] valid_reg;
    logic [7:0]           rdata_reg;
    logic                 raddr_ok;

    assign raddr_ok = ({1'b0, raddr} < DEPTH_W);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (raddr_ok && valid_reg[raddr])
        begin
            rdata_reg <= mem[raddr];
        end
        else
        begin
            rdata_reg <= '0;
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hdl/ufc_checker.sv -----
// ----------------------------------------------------------------------------
// ufc_checker
// frame check sequencer: walks the store through one read port, one shared
// 16-bit accumulator, then header and trailer reads and the status decision
// ----------------------------------------------------------------------------
`default_nettype none

module ufc_checker
    import ufc_pkg::*;
#(
    parameter int BUF_DEPTH = UFC_BUF_DEPTH,
    parameter int AW        = $clog2(BUF_DEPTH)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire chk_req_t      req,
    input  wire logic [7:0]    start_byte,
    input  wire logic [7:0]    address_byte,
    output logic      [AW-1:0] raddr,
    input  wire logic [7:0]    rdata,
    output chk_res_t           res,
    input  wire logic          res_ready
);

    localparam logic [8:0] DEPTH_9 = 9'(BUF_DEPTH);

    chk_state_t    state_reg, state_next;
    chk_state_t    prev_reg;
    logic [7:0]    n_reg;
    logic          big_reg;
    logic [AW-1:0] walk_reg;
    logic [15:0]   acc_reg;
    logic [7:0]    lo_reg, hi_reg, b0_reg, b1_reg, len_reg, cmd_reg, cr_reg, lf_reg;
    logic [AW-1:0] sum_end;
    logic [8:0]    trail_cr_addr;
    logic [8:0]    trail_end;
    status_t       status;
    logic          res_valid;

    assign sum_end       = n_reg[AW-1:0] - AW'(5);
    assign trail_cr_addr = {1'b0, len_reg} + 9'd6;
    assign trail_end     = {1'b0, len_reg} + 9'd7;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            prev_reg  <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            prev_reg  <= state_reg;
        end
    end

    // frame length, walk pointer and accumulator
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req.start)
        begin
            n_reg    <= req.nbytes;
            big_reg  <= (req.nbytes >= 8'd8);
            walk_reg <= AW'(1);
            acc_reg  <= '0;
        end
        else
        begin
            if (state_reg == S_SUM)
            begin
                walk_reg <= walk_reg + AW'(1);
            end
            if (prev_reg == S_SUM)
            begin
                acc_reg <= acc_reg + {8'b0, rdata};
            end
        end
    end

    // read data lands in the cycle after its address was issued
    always_ff @(posedge clk)
    begin
        unique case (prev_reg)
            S_CKLO:  lo_reg  <= rdata;
            S_CKHI:  hi_reg  <= rdata;
            S_HB0:   b0_reg  <= rdata;
            S_HB1:   b1_reg  <= rdata;
            S_HB3:   len_reg <= rdata;
            S_HB4:   cmd_reg <= rdata;
            S_TCR:   cr_reg  <= rdata;
            S_TLF:   lf_reg  <= rdata;
            default: ;
        endcase
    end

    always_comb
    begin
        priority if (big_reg && (acc_reg != {hi_reg, lo_reg}))
            status = ST_CKSUM_ERR;
        else if (b0_reg != start_byte || b1_reg != address_byte)
            status = ST_FRAME_ERR;
        else if (trail_end >= DEPTH_9)
            status = ST_FRAME_ERR;
        else if (cr_reg != UFC_TRAIL_CR || lf_reg != UFC_TRAIL_LF)
            status = ST_FRAME_ERR;
        else
            status = ST_FRAME_OK;
    end

    always_comb
    begin
        state_next = state_reg;
        raddr      = '0;
        res_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    state_next = (req.nbytes >= 8'd8) ? S_SUM : S_HB0;
                end
            end
            S_SUM:
            begin
                raddr = walk_reg;
                if (walk_reg == sum_end)
                begin
                    state_next = S_CKLO;
                end
            end
            S_CKLO:
            begin
                raddr      = n_reg[AW-1:0] - AW'(4);
                state_next = S_CKHI;
            end
            S_CKHI:
            begin
                raddr      = n_reg[AW-1:0] - AW'(3);
                state_next = S_HB0;
            end
            S_HB0:
            begin
                raddr      = AW'(0);
                state_next = S_HB1;
            end
            S_HB1:
            begin
                raddr      = AW'(1);
                state_next = S_HB3;
            end
            S_HB3:
            begin
                raddr      = AW'(3);
                state_next = S_HB4;
            end
            S_HB4:
            begin
                raddr      = AW'(4);
                state_next = S_TCR;
            end
            S_TCR:
            begin
                raddr      = trail_cr_addr[AW-1:0];
                state_next = S_TLF;
            end
            S_TLF:
            begin
                raddr      = trail_end[AW-1:0];
                state_next = S_FIN;
            end
            S_FIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // valid, status, command, length_field, frame_bytes
    assign res = {res_valid, status, cmd_reg, len_reg, n_reg};

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == S_IDLE)
        else $error("check started while sequencer busy");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SUM |-> walk_reg <= sum_end && big_reg)
        else $error("checksum walk out of range");

    a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN |=> state_reg == S_DONE && prev_reg == S_FIN)
        else $error("sequencer skipped result stage");

endmodule

`default_nettype wire

// ----- hdl/uart_idle_gap_frame_checker.sv -----
// ----------------------------------------------------------------------------
// uart_idle_gap_frame_checker
// collects uart bytes into a frame store and checks the frame once the line
// has been idle for idle_timeout ticks
// ----------------------------------------------------------------------------
// a beat that does not close a frame leaves s_tready high for the next beat
// a closing beat holds s_tready low until the checker result is loaded; the
// single read port of the frame store walks one byte a cycle
// the result is loaded into the output register when it is free
// reset: asynchronous, active low; clears counters, registers to reset values
// and the valid bits of the frame store, so no clearing pass is needed
`default_nettype none

module uart_idle_gap_frame_checker
    import ufc_pkg::*;
#(
    parameter int BUF_DEPTH = UFC_BUF_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        s_tuser,   // [0] mode
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [1:0] status, [9:2] command,
                                        // [17:10] length_field, [25:18] frame_bytes
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [19:0] cfg_data
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam logic [AW-1:0] CNT_LAST = AW'(BUF_DEPTH - 1);

    // configuration registers
    logic [19:0] timeout_reg;
    logic [7:0]  start_reg;
    logic [7:0]  address_reg;

    // frame collection state
    logic [AW-1:0] byte_cnt_reg;
    logic          pend_reg;
    logic [19:0]   idle_cnt_reg;
    logic          busy_reg;

    // output register
    logic          out_valid_reg;
    status_t       out_status_reg;
    logic [7:0]    out_cmd_reg;
    logic [7:0]    out_len_reg;
    logic [7:0]    out_nbytes_reg;

    // step of one accepted beat
    logic          in_beat;
    logic          is_byte;
    logic [AW-1:0] cnt_inc;
    logic [AW-1:0] cnt_after;
    logic          pend_after;
    logic [19:0]   idle_after;
    logic          close_frame;

    // checker link
    chk_req_t      chk_req;
    chk_res_t      chk_res;
    logic          res_ready;
    logic          res_take;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    assign cfg_ready = 1'b1;
    assign s_tready  = !busy_reg;
    assign in_beat   = s_tvalid && s_tready;
    assign is_byte   = s_tuser;

    // byte pointer wraps at the buffer depth
    assign cnt_inc    = (byte_cnt_reg == CNT_LAST) ? '0 : byte_cnt_reg + AW'(1);
    assign cnt_after  = is_byte ? cnt_inc : byte_cnt_reg;
    assign pend_after = is_byte || pend_reg;

    // idle ticks saturate at the timeout, a byte restarts the gap
    always_comb
    begin
        if (is_byte)
            idle_after = '0;
        else if (idle_cnt_reg < timeout_reg)
            idle_after = idle_cnt_reg + 20'd1;
        else
            idle_after = idle_cnt_reg;
    end

    // a zero timeout closes the frame on the byte beat itself
    assign close_frame = pend_after && (idle_after >= timeout_reg);

    assign chk_req.start  = in_beat && close_frame;
    assign chk_req.nbytes = 8'(cnt_after);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= UFC_TIMEOUT_RST;
            start_reg   <= UFC_START_RST;
            address_reg <= UFC_ADDRESS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_IDLE_TIMEOUT: timeout_reg <= cfg_data;
                REG_START_BYTE:   start_reg   <= cfg_data[7:0];
                REG_ADDRESS_BYTE: address_reg <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_cnt_reg <= '0;
            pend_reg     <= 1'b0;
            idle_cnt_reg <= '0;
            busy_reg     <= 1'b0;
        end
        else
        begin
            if (in_beat)
            begin
                if (close_frame)
                begin
                    byte_cnt_reg <= '0;
                    pend_reg     <= 1'b0;
                    idle_cnt_reg <= '0;
                    busy_reg     <= 1'b1;
                end
                else
                begin
                    byte_cnt_reg <= cnt_after;
                    pend_reg     <= pend_after;
                    idle_cnt_reg <= idle_after;
                end
            end
            else if (res_take)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // frame store, written at the current pointer on a byte beat
    ufc_frame_mem #(
        .BUF_DEPTH (BUF_DEPTH),
        .AW        (AW)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (in_beat && is_byte),
        .waddr (byte_cnt_reg),
        .wdata (s_tdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // checksum walk and header / trailer checks
    ufc_checker #(
        .BUF_DEPTH (BUF_DEPTH),
        .AW        (AW)
    ) u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (chk_req),
        .start_byte   (start_reg),
        .address_byte (address_reg),
        .raddr        (mem_raddr),
        .rdata        (mem_rdata),
        .res          (chk_res),
        .res_ready    (res_ready)
    );

    // output register takes a result when empty or draining this cycle
    assign res_ready = !out_valid_reg || m_tready;
    assign res_take  = chk_res.valid && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_status_reg <= chk_res.status;
            out_cmd_reg    <= chk_res.command;
            out_len_reg    <= chk_res.length_field;
            out_nbytes_reg <= chk_res.frame_bytes;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_nbytes_reg, out_len_reg, out_cmd_reg, out_status_reg};

    a_close_starts_check: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && close_frame |=> busy_reg && byte_cnt_reg == '0 && !pend_reg)
        else $error("frame close did not start the check");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_cnt_reg <= CNT_LAST)
        else $error("byte count beyond buffer depth");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        res_take |=> out_valid_reg && !busy_reg)
        else $error("checker result lost");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// drives uart bytes and idle ticks into the frame checker under random
// backpressure, mirrors the frame store and close logic in a local model and
// checks every status beat field by field against the expected frame verdicts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import ufc_pkg::*;

    localparam int          STORE_DEPTH   = UFC_BUF_DEPTH;
    localparam int          STALL_LIMIT   = 4000;   // quiet cycles before giving up
    localparam int          SETTLE_CYCLES = 300;    // longer than the longest frame walk
    localparam logic [1:0]  REG_SPARE     = 2'd3;   // index with no register behind it
    localparam logic [19:0] TIMEOUT_MAX   = 20'hfffff;

    // ways a generated frame can be broken
    localparam int FLAW_NONE  = 0;
    localparam int FLAW_CKSUM = 1;
    localparam int FLAW_START = 2;
    localparam int FLAW_ADDR  = 3;
    localparam int FLAW_CR    = 4;
    localparam int FLAW_LF    = 5;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } uart_beat_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [19:0] data;
    } reg_write_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] command;
        logic [7:0] length_field;
        logic [7:0] frame_bytes;
    } frame_result_t;

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [19:0] cfg_data  = 20'd0;

    uart_idle_gap_frame_checker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // shared queues and knobs
    // ------------------------------------------------------------------------
    uart_beat_t    tx_beats[$];          // beats waiting to go onto the input stream
    reg_write_t    cfg_writes[$];        // register writes waiting for the cfg channel
    frame_result_t awaited_results[$];   // frame verdicts not yet seen on the output

    int send_gap_pct   = 0;   // chance per free slot that the sender holds off
    int recv_stall_pct = 0;   // chance per cycle that the receiver drops tready
    int mismatches     = 0;
    int results_seen   = 0;
    int quiet_cycles   = 0;
    int tx_total       = 0;   // beats queued so far, sizes the random part

    // ------------------------------------------------------------------------
    // local model of the checker: frame store, counters and registers
    // ------------------------------------------------------------------------
    logic [7:0]  mirror_store [STORE_DEPTH] = '{default: 8'h00};
    logic [7:0]  mirror_count   = 8'd0;    // wraps at 256 like the buffer index
    logic        mirror_pending = 1'b0;
    logic [19:0] mirror_idle    = 20'd0;
    logic [19:0] mirror_timeout = UFC_TIMEOUT_RST;
    logic [7:0]  mirror_start   = UFC_START_RST;
    logic [7:0]  mirror_address = UFC_ADDRESS_RST;

    // verdict on the frame currently held in the mirrored store
    function automatic status_t frame_verdict();
        int          n;
        int          len;
        int          i;
        logic [15:0] sum;
        logic [15:0] word;
        n   = mirror_count;
        sum = 16'd0;
        // checksum only applies to frames of eight bytes or more
        if (n >= 8)
        begin
            for (i = 1; i <= n - 5; i++)
                sum = sum + 16'(mirror_store[i]);
            word = {mirror_store[n - 3], mirror_store[n - 4]};
            if (sum != word)
                return ST_CKSUM_ERR;
        end
        len = mirror_store[3];
        if (mirror_store[0] != mirror_start || mirror_store[1] != mirror_address)
            return ST_FRAME_ERR;
        // trailer would sit past the end of the buffer
        if (len + 7 >= STORE_DEPTH)
            return ST_FRAME_ERR;
        if (mirror_store[len + 6] != UFC_TRAIL_CR || mirror_store[len + 7] != UFC_TRAIL_LF)
            return ST_FRAME_ERR;
        return ST_FRAME_OK;
    endfunction

    // advance the model by one accepted input beat
    task automatic absorb_beat(uart_beat_t b);
        frame_result_t r;
        if (b.mode)
        begin
            mirror_store[mirror_count] = b.rx_byte;
            mirror_count   = mirror_count + 8'd1;
            mirror_pending = 1'b1;
            mirror_idle    = 20'd0;
        end
        else if (mirror_idle < mirror_timeout && mirror_idle != TIMEOUT_MAX)
        begin
            // idle time saturates at the timeout
            mirror_idle = mirror_idle + 20'd1;
        end
        // a zero timeout closes the frame on the byte beat itself
        if (mirror_pending && mirror_idle >= mirror_timeout)
        begin
            r.status       = frame_verdict();
            r.command      = mirror_store[4];
            r.length_field = mirror_store[3];
            r.frame_bytes  = mirror_count;
            awaited_results.push_back(r);
            mirror_pending = 1'b0;
            mirror_idle    = 20'd0;
            mirror_count   = 8'd0;
        end
    endtask

    task automatic apply_reg_write(reg_write_t w);
        case (w.index)
            REG_IDLE_TIMEOUT: mirror_timeout = w.data;
            REG_START_BYTE:   mirror_start   = w.data[7:0];
            REG_ADDRESS_BYTE: mirror_address = w.data[7:0];
            default:          ;   // spare index, write is dropped
        endcase
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on result %0d, %0s: got 0x%0h, expected 0x%0h",
                 results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic check_result(logic [31:0] word);
        frame_result_t want;
        if (awaited_results.size() == 0)
        begin
            report_mismatch("result with no frame closed", word, 32'd0);
        end
        else
        begin
            want = awaited_results.pop_front();
            if (word[1:0] !== want.status)
                report_mismatch("status", 32'(word[1:0]), 32'(want.status));
            if (word[9:2] !== want.command)
                report_mismatch("command", 32'(word[9:2]), 32'(want.command));
            if (word[17:10] !== want.length_field)
                report_mismatch("length_field", 32'(word[17:10]), 32'(want.length_field));
            if (word[25:18] !== want.frame_bytes)
                report_mismatch("frame_bytes", 32'(word[25:18]), 32'(want.frame_bytes));
            if (word[31:26] !== 6'd0)
                report_mismatch("tdata padding", 32'(word[31:26]), 32'd0);
        end
        results_seen++;
    endtask

    // ------------------------------------------------------------------------
    // input stream driver: one beat per accept, random gaps between beats
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tuser  <= 1'b0;
        end
        else
        begin
            // the beat on the bus is taken at this edge
            if (s_tvalid && s_tready)
                absorb_beat(uart_beat_t'({s_tuser, s_tdata}));
            // slot is free after this edge: load the next beat or go idle
            if (!s_tvalid || s_tready)
            begin
                if (tx_beats.size() > 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= tx_beats[0].mode;
                    s_tdata  <= tx_beats[0].rx_byte;
                    tx_beats.delete(0);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // configuration channel driver
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
            cfg_index <= 2'd0;
            cfg_data  <= 20'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_reg_write(reg_write_t'({cfg_index, cfg_data}));
            if (!cfg_valid || cfg_ready)
            begin
                if (cfg_writes.size() > 0)
                begin
                    cfg_valid <= 1'b1;
                    cfg_index <= cfg_writes[0].index;
                    cfg_data  <= cfg_writes[0].data;
                    cfg_writes.delete(0);
                end
                else
                begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor with random receiver stalls
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any beat on any channel means a hang
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles + 1 >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus side: shadow of the registers used to shape frames
    // ------------------------------------------------------------------------
    int         gen_timeout = UFC_TIMEOUT_RST;
    logic [7:0] gen_start   = UFC_START_RST;
    logic [7:0] gen_address = UFC_ADDRESS_RST;

    function automatic logic [7:0] nonzero_byte();
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic set_idling(int send_pct, int recv_pct);
        send_gap_pct   = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic set_reg(logic [1:0] index, logic [19:0] value);
        logic [19:0] data;
        data = value;
        // byte registers ignore the upper bits, so fill them with junk
        if (index == REG_START_BYTE || index == REG_ADDRESS_BYTE)
            data[19:8] = 12'($urandom_range(4095));
        cfg_writes.push_back(reg_write_t'({index, data}));
        case (index)
            REG_IDLE_TIMEOUT: gen_timeout = value;
            REG_START_BYTE:   gen_start   = value[7:0];
            REG_ADDRESS_BYTE: gen_address = value[7:0];
            default:          ;
        endcase
    endtask

    task automatic push_beat(logic mode, logic [7:0] value);
        tx_beats.push_back(uart_beat_t'({mode, value}));
        tx_total++;
    endtask

    task automatic push_byte(logic [7:0] value);
        push_beat(1'b1, value);
    endtask

    // idle ticks carry random data that the block must ignore
    task automatic push_ticks(int count);
        repeat (count) push_beat(1'b0, 8'($urandom_range(255)));
    endtask

    task automatic close_frame();
        push_ticks(gen_timeout + $urandom_range(0, 2));
    endtask

    // header, length, payload, checksum, cr lf; optionally one field broken
    task automatic push_frame(int len, int flaw);
        logic [7:0]  fb[$];
        logic [15:0] sum;
        int          i;
        fb.push_back(flaw == FLAW_START ? gen_start ^ nonzero_byte() : gen_start);
        fb.push_back(flaw == FLAW_ADDR ? gen_address ^ nonzero_byte() : gen_address);
        fb.push_back(8'($urandom_range(255)));
        fb.push_back(8'(len));
        for (i = 0; i < len; i++)
            fb.push_back(8'($urandom_range(255)));
        sum = 16'd0;
        for (i = 1; i < fb.size(); i++)
            sum = sum + 16'(fb[i]);
        if (flaw == FLAW_CKSUM)
            sum = sum ^ 16'(nonzero_byte());
        fb.push_back(sum[7:0]);
        fb.push_back(sum[15:8]);
        fb.push_back(flaw == FLAW_CR ? UFC_TRAIL_CR ^ nonzero_byte() : UFC_TRAIL_CR);
        fb.push_back(flaw == FLAW_LF ? UFC_TRAIL_LF ^ nonzero_byte() : UFC_TRAIL_LF);
        foreach (fb[k])
            push_byte(fb[k]);
        close_frame();
    endtask

    // fewer than eight bytes: checksum skipped, trailer read from stale store
    task automatic push_short_frame();
        int n;
        int i;
        n = $urandom_range(1, 7);
        for (i = 0; i < n; i++)
        begin
            if (i == 0 && $urandom_range(1) == 1)
                push_byte(gen_start);
            else if (i == 1 && $urandom_range(1) == 1)
                push_byte(gen_address);
            else if (i == 3 && $urandom_range(1) == 1)
                push_byte(8'($urandom_range(0, 2)));
            else
                push_byte(8'($urandom_range(255)));
        end
        close_frame();
    endtask

    // random bytes with idle gaps too short to close, then a real close
    task automatic push_noise();
        int k;
        k = $urandom_range(1, 12);
        if ($urandom_range(3) == 0)
            push_ticks($urandom_range(1, 5));   // ticks with nothing pending
        repeat (k)
        begin
            push_byte(8'($urandom_range(255)));
            if ($urandom_range(3) == 0 && gen_timeout > 1)
                push_ticks($urandom_range(0, gen_timeout - 1));
        end
        close_frame();
    endtask

    task automatic push_random_frame();
        int pick;
        int len;
        pick = $urandom_range(99);
        len  = ($urandom_range(9) == 0) ? $urandom_range(11, 60) : $urandom_range(0, 10);
        if (pick < 70)
            push_frame(len, ($urandom_range(99) < 70) ? FLAW_NONE : $urandom_range(1, 5));
        else if (pick < 85)
            push_short_frame();
        else
            push_noise();
    endtask

    // wait until all queued beats and writes are out and every verdict is in;
    // sampled on the falling edge so all beats of the rising edge have settled
    task automatic wait_drained();
        while (tx_beats.size() != 0 || s_tvalid || awaited_results.size() != 0 ||
               cfg_writes.size() != 0 || cfg_valid)
            @(negedge clk);
    endtask

    task automatic wait_settled();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int p;
        int frames;
        int first_beat;

        set_idling(0, 0);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: start and address bytes left at their reset values,
        // a write to the spare index must change nothing
        set_reg(REG_SPARE, 20'($urandom_range(20'hfffff)));
        set_reg(REG_IDLE_TIMEOUT, 20'd4);
        wait_drained();
        push_frame(0, FLAW_NONE);
        push_frame(1, FLAW_NONE);
        push_frame(3, FLAW_CKSUM);
        push_frame(2, FLAW_START);
        push_frame(2, FLAW_ADDR);
        push_frame(4, FLAW_CR);
        push_frame(4, FLAW_LF);
        push_ticks(10);                          // idle with no frame pending
        push_byte(gen_start);                    // short frame, stale trailer
        push_byte(gen_address);
        push_byte(8'h00);
        push_byte(8'h00);
        close_frame();
        push_byte(gen_start);                    // trailer beyond the buffer end
        push_byte(gen_address);
        push_byte(8'hff);
        push_byte(8'hff);
        push_byte(8'h00);
        close_frame();
        push_frame(5, FLAW_NONE);
        wait_settled();

        // zero timeout: every byte closes a one byte frame on its own beat
        set_idling(65, 0);
        set_reg(REG_IDLE_TIMEOUT, 20'd0);
        set_reg(REG_START_BYTE, 20'h000);
        set_reg(REG_ADDRESS_BYTE, 20'h0ff);
        wait_settled();
        repeat (12)
        begin
            push_byte(8'($urandom_range(255)));
            if ($urandom_range(1) == 1)
                push_ticks($urandom_range(0, 2));
        end
        push_frame(2, FLAW_NONE);
        wait_settled();

        // largest timeout: a frame stays open, then a shorter timeout closes it
        set_idling(0, 65);
        set_reg(REG_IDLE_TIMEOUT, TIMEOUT_MAX);
        set_reg(REG_START_BYTE, 20'h0ff);
        set_reg(REG_ADDRESS_BYTE, 20'h000);
        wait_settled();
        push_byte(8'hff);
        push_byte(8'h00);
        repeat (4) push_byte(8'($urandom_range(255)));
        push_ticks(8);
        wait_settled();
        set_reg(REG_IDLE_TIMEOUT, 20'd3);
        wait_settled();
        push_ticks(1);
        wait_settled();

        // buffer overflow with an idle timeout of one tick
        set_idling(9, 9);
        set_reg(REG_IDLE_TIMEOUT, 20'd1);
        set_reg(REG_START_BYTE, 20'h03a);
        set_reg(REG_ADDRESS_BYTE, 20'h016);
        wait_settled();
        push_frame(249, FLAW_NONE);              // count wraps and overwrites byte 0
        wait_settled();

        // random frames, one idling pattern per phase, fresh registers each time
        for (p = 0; p < 4; p++)
        begin
            case (p)
                0:       set_idling(0, 0);
                1:       set_idling(65, 0);
                2:       set_idling(0, 65);
                default: set_idling(9, 9);
            endcase
            set_reg(REG_IDLE_TIMEOUT, 20'($urandom_range(1, 6)));
            set_reg(REG_START_BYTE, 20'($urandom_range(255)));
            set_reg(REG_ADDRESS_BYTE, 20'($urandom_range(255)));
            wait_settled();
            frames     = 0;
            first_beat = tx_total;
            while (tx_total - first_beat < 10 || frames < 1)
            begin
                push_random_frame();
                frames++;
                // after the first frame the sender holds off until its verdict has come back
                if (frames == 1)
                    wait_drained();
            end
            wait_settled();
        end

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/ufc_pkg.sv
hdl/ufc_frame_mem.sv
hdl/ufc_checker.sv
hdl/uart_idle_gap_frame_checker.sv
sim/testbench.sv
